FILE: sv/lta_pkg.sv
package lta_pkg;

  localparam int GRID_SIDE_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAT,
    ST_DIV,
    ST_GLOW,
    ST_MIXR,
    ST_MIXW,
    ST_SPARK,
    ST_SPARKW,
    ST_PIX,
    ST_COLR,
    ST_OUT
  } lta_state_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_PASS
  } lta_op_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[WORD_W-1:0];
  endfunction

endpackage

FILE: sv/lta_if.sv
interface lta_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       spark;
  logic [7:0] pixel_index;
  modport source (output valid, func, spark, pixel_index, input ready);
  modport sink (input valid, func, spark, pixel_index, output ready);
endinterface

interface lta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: sv/lava_texture_automaton_unit.sv
// Channel | Direction | Handshake     | Payload
// in_     | input     | valid / ready | func, spark, pixel_index
// out_    | output    | valid / ready | red, green, blue
// cfg_    | input     | write enable  | scroll_enable (1 bit)
//
// A cell update holds the block from the accepting cycle through neighbour
// heat reads, division by ten, glow reads and the mix, glow and spark updates,
// all through one shared add/multiply unit and the single read port of each
// memory. A pixel read holds it through the heat fetch, the colour steps and
// the write of the output register.
// Reset is synchronous and active low; the memories are cleared by a pass over
// all GRID_SIDE^2 cells after reset, during which no item is accepted.
// A result waits in the output register while out_ready is low. The next item
// is still accepted; a later read waits after its fetch until the register
// has been taken.
module lava_texture_automaton_unit #(
  parameter int GRID_SIDE = lta_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = lta_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  lta_in_if.sink   in_ch,
  lta_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);
  import lta_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(GRID_SIDE);
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] K_GAIN = ((64'sd1 <<< FRAC_BITS) + 50) / 100;
  localparam logic signed [63:0] K_DECAY = ((64'sd6 <<< FRAC_BITS) + 50) / 100;
  localparam logic signed [63:0] K_SET = (64'sd3 <<< FRAC_BITS) / 2;
  localparam logic signed [63:0] K_MIX = ((64'sd4 <<< FRAC_BITS) + 2) / 5;

  // Skew of a coordinate: +1 in the first lobe of the sine, -1 in the second.
  function automatic logic signed [2:0] skew(input logic [CW-1:0] v);
    logic signed [63:0] num;
    num = 64'(v) * 1000000;
    if (num >= 156785 * GRID_SIDE && num <= 343215 * GRID_SIDE) return 3'sd1;
    if (num >= 656785 * GRID_SIDE && num <= 843215 * GRID_SIDE) return -3'sd1;
    return 3'sd0;
  endfunction

  lta_state_t state_r, state_nxt;
  logic [AW-1:0] cell_r, cell_nxt;
  logic          bsel_r, bsel_nxt;
  logic [CW-1:0] frm_row_r, frm_row_nxt;
  logic [1:0]    frm_ph_r, frm_ph_nxt;
  logic          scroll_r;
  logic [3:0]    step_r, step_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] tmp_r, tmp_nxt;
  logic          neg_r, neg_nxt;
  logic          spark_r, spark_nxt;
  logic [AW-1:0] pix_r, pix_nxt;
  logic          clr_r, clr_nxt;
  logic [AW:0]   clr_cnt_r, clr_cnt_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    red_r, red_nxt, grn_r, grn_nxt, blu_r, blu_nxt;

  // Memories: heat buffers A and B, glow and spark energy.
  logic ha_we, hb_we, g_we, s_we;
  logic [AW-1:0] ha_wa, hb_wa, g_wa, s_wa, ha_ra, hb_ra, g_ra, s_ra;
  logic signed [WORD_W-1:0] ha_wd, hb_wd, g_wd, s_wd, ha_rd, hb_rd, g_rd, s_rd;

  lta_mem #(.DEPTH(CELLS), .AW(AW)) u_ha (.clk, .we(ha_we), .waddr(ha_wa),
    .wdata(ha_wd), .raddr(ha_ra), .rdata(ha_rd));
  lta_mem #(.DEPTH(CELLS), .AW(AW)) u_hb (.clk, .we(hb_we), .waddr(hb_wa),
    .wdata(hb_wd), .raddr(hb_ra), .rdata(hb_rd));
  lta_mem #(.DEPTH(CELLS), .AW(AW)) u_g (.clk, .we(g_we), .waddr(g_wa),
    .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  lta_mem #(.DEPTH(CELLS), .AW(AW)) u_s (.clk, .we(s_we), .waddr(s_wa),
    .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  lta_op_t alu_op;
  logic signed [63:0] alu_a, alu_b, alu_y;
  lta_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

  // Cell coordinates: the counter runs x-major, so x is the high digit.
  logic [CW-1:0] cx, cy, cx1, cy1;
  logic [AW-1:0] idx;
  logic signed [2:0] sx, sy;
  logic [CW-1:0] nbx, nby;
  logic [1:0] ndx, ndy;
  logic signed [WORD_W-1:0] front_rd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] off;

  assign cx = cell_r[AW-1:CW];
  assign cy = cell_r[CW-1:0];
  assign cx1 = cx + 1'b1;
  assign cy1 = cy + 1'b1;
  assign idx = {cy, cx};
  assign sx = skew(cx);
  assign sy = skew(cy);

  // Neighbour offsets for each heat read step, x outer and y inner.
  always_comb begin
    case (step_r)
      4'd0: begin ndx = 2'd0; ndy = 2'd0; end
      4'd1: begin ndx = 2'd0; ndy = 2'd1; end
      4'd2: begin ndx = 2'd0; ndy = 2'd2; end
      4'd3: begin ndx = 2'd1; ndy = 2'd0; end
      4'd4: begin ndx = 2'd1; ndy = 2'd1; end
      4'd5: begin ndx = 2'd1; ndy = 2'd2; end
      4'd6: begin ndx = 2'd2; ndy = 2'd0; end
      4'd7: begin ndx = 2'd2; ndy = 2'd1; end
      4'd8: begin ndx = 2'd2; ndy = 2'd2; end
      default: begin ndx = 2'd0; ndy = 2'd0; end
    endcase
  end

  assign nbx = CW'($signed({1'b0, cx}) + $signed({2'b0, ndx}) - 1 + sy);
  assign nby = CW'($signed({1'b0, cy}) + $signed({2'b0, ndy}) - 1 + sx);
  assign front_rd = bsel_r ? hb_rd : ha_rd;
  // The scroll moves one row for every three completed frames.
  assign off = AW'({frm_row_r, CW'(0)});

  always_comb begin
    state_nxt = state_r;
    cell_nxt = cell_r;
    bsel_nxt = bsel_r;
    frm_row_nxt = frm_row_r;
    frm_ph_nxt = frm_ph_r;
    step_nxt = step_r;
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    neg_nxt = neg_r;
    spark_nxt = spark_r;
    pix_nxt = pix_r;
    clr_nxt = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    ov_nxt = ov_r;
    red_nxt = red_r;
    grn_nxt = grn_r;
    blu_nxt = blu_r;
    ha_we = 1'b0; hb_we = 1'b0; g_we = 1'b0; s_we = 1'b0;
    ha_wa = idx; hb_wa = idx; g_wa = idx; s_wa = idx;
    ha_wd = '0; hb_wd = '0; g_wd = '0; s_wd = '0;
    rd_addr = idx;
    alu_op = OP_PASS;
    alu_a = acc_r;
    alu_b = '0;
    in_ch.ready = 1'b0;

    if (out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (clr_r) begin
          // Clearing pass over every memory after reset.
          ha_we = 1'b1; hb_we = 1'b1; g_we = 1'b1; s_we = 1'b1;
          ha_wa = clr_cnt_r[AW-1:0]; hb_wa = ha_wa; g_wa = ha_wa; s_wa = ha_wa;
          clr_cnt_nxt = clr_cnt_r + 1'b1;
          if (clr_cnt_r == (AW+1)'(CELLS - 1)) clr_nxt = 1'b0;
        end else begin
          in_ch.ready = 1'b1;
          if (in_ch.valid) begin
            step_nxt = '0;
            acc_nxt = '0;
            spark_nxt = in_ch.spark;
            if (in_ch.func) begin
              pix_nxt = scroll_r ? AW'(in_ch.pixel_index) - off
                                 : AW'(in_ch.pixel_index);
              state_nxt = ST_PIX;
            end else begin
              state_nxt = ST_HEAT;
            end
          end
        end
      end
      // Nine neighbour reads; data arrives in the cycle after each address.
      ST_HEAT: begin
        rd_addr = {nby, nbx};
        if (step_r != 0) begin
          alu_op = OP_ADD;
          alu_b = 64'(front_rd);
          acc_nxt = alu_y;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd9) begin
          step_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      // Signed division of the neighbour sum by ten, truncated toward zero.
      // The magnitude is scaled by one tenth with shifts and adds, the
      // remainder then corrects the quotient by one, and the sign goes back on.
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        alu_op = OP_ADD;
        case (step_r)
          4'd0: begin
            neg_nxt = acc_r[63];
            alu_op = OP_SUB;
            alu_a = '0;
            alu_b = acc_r;
            if (acc_r[63]) acc_nxt = alu_y;
          end
          4'd1: begin
            alu_a = acc_r >>> 1;
            alu_b = acc_r >>> 2;
            tmp_nxt = alu_y;
          end
          4'd2: begin
            alu_a = tmp_r;
            alu_b = tmp_r >>> 4;
            tmp_nxt = alu_y;
          end
          4'd3: begin
            alu_a = tmp_r;
            alu_b = tmp_r >>> 8;
            tmp_nxt = alu_y;
          end
          4'd4: begin
            alu_a = tmp_r;
            alu_b = tmp_r >>> 16;
            tmp_nxt = alu_y;
          end
          4'd5: begin
            alu_a = tmp_r;
            alu_b = tmp_r >>> 32;
            tmp_nxt = alu_y;
          end
          4'd6: begin
            alu_op = OP_PASS;
            alu_a = tmp_r >>> 3;
            tmp_nxt = alu_y;
          end
          4'd7: begin
            alu_op = OP_SUB;
            alu_a = acc_r;
            alu_b = tmp_r <<< 3;
            acc_nxt = alu_y;
          end
          4'd8: begin
            alu_op = OP_SUB;
            alu_a = acc_r;
            alu_b = tmp_r <<< 1;
            acc_nxt = alu_y;
          end
          4'd9: begin
            alu_a = tmp_r;
            alu_b = (acc_r > 64'sd9) ? 64'sd1 : 64'sd0;
            tmp_nxt = alu_y;
          end
          default: begin
            alu_op = OP_SUB;
            alu_a = '0;
            alu_b = tmp_r;
            if (neg_r) tmp_nxt = alu_y;
            acc_nxt = '0;
            step_nxt = '0;
            state_nxt = ST_GLOW;
          end
        endcase
      end
      // Four glow reads, summed in the accumulator and divided by four.
      ST_GLOW: begin
        case (step_r)
          4'd0: rd_addr = idx;
          4'd1: rd_addr = {cy, cx1};
          4'd2: rd_addr = {cy1, cx1};
          default: rd_addr = {cy1, cx};
        endcase
        if (step_r != 0) begin
          alu_op = OP_ADD;
          alu_b = 64'(g_rd);
          acc_nxt = alu_y;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd4) begin
          acc_nxt = alu_y / 4;
          step_nxt = '0;
          state_nxt = ST_MIXR;
        end
      end
      ST_MIXR: begin
        alu_op = OP_MUL;
        alu_b = K_MIX;
        acc_nxt = alu_y;
        state_nxt = ST_MIXW;
      end
      ST_MIXW: begin
        alu_op = OP_ADD;
        alu_b = tmp_r;
        if (bsel_r) begin
          ha_we = 1'b1; ha_wd = sat32(alu_y);
        end else begin
          hb_we = 1'b1; hb_wd = sat32(alu_y);
        end
        rd_addr = idx;
        state_nxt = ST_SPARK;
      end
      // Glow and spark reads of this cell are ready now.
      ST_SPARK: begin
        alu_op = OP_MUL;
        alu_a = 64'(s_rd);
        alu_b = K_GAIN;
        acc_nxt = alu_y;
        tmp_nxt = 64'(s_rd);
        state_nxt = ST_SPARKW;
        if (step_r == 0) begin
          acc_nxt = alu_y + 64'(g_rd);
        end
      end
      ST_SPARKW: begin
        g_we = 1'b1;
        g_wd = sat32(acc_r);
        if (g_wd < 0) g_wd = '0;
        alu_op = OP_SUB;
        alu_a = tmp_r;
        alu_b = K_DECAY;
        s_we = 1'b1;
        s_wd = spark_r ? WORD_W'(K_SET) : sat32(alu_y);
        cell_nxt = cell_r + 1'b1;
        if (cell_r == AW'(CELLS - 1)) begin
          bsel_nxt = !bsel_r;
          if (frm_ph_r == 2'd2) begin
            frm_ph_nxt = '0;
            frm_row_nxt = frm_row_r + 1'b1;
          end else begin
            frm_ph_nxt = frm_ph_r + 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      // The fetched heat is kept on the read port until the previous result
      // has left the output register.
      ST_PIX: begin
        rd_addr = pix_r;
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd1) begin
          step_nxt = step_r;
          if (!ov_r || out_ch.ready) begin
            acc_nxt = 64'(front_rd) * 2;
            if (acc_nxt > Q_ONE) acc_nxt = Q_ONE;
            if (acc_nxt < 0) acc_nxt = '0;
            step_nxt = '0;
            state_nxt = ST_COLR;
          end
        end
      end
      // acc holds L; tmp takes L2, then the colours follow.
      ST_COLR: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          4'd0: begin
            alu_op = OP_MUL;
            alu_b = acc_r;
            tmp_nxt = alu_y;
            red_nxt = 8'((155 * Q_ONE + 100 * acc_r) >>> FRAC_BITS);
          end
          4'd1: begin
            grn_nxt = 8'((255 * tmp_r) >>> FRAC_BITS);
            alu_op = OP_MUL;
            alu_a = tmp_r;
            alu_b = tmp_r;
            acc_nxt = alu_y;
          end
          default: begin
            blu_nxt = 8'((128 * acc_r) >>> FRAC_BITS);
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ha_ra = rd_addr;
  assign hb_ra = rd_addr;
  assign g_ra = rd_addr;
  assign s_ra = rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cell_r <= '0;
      bsel_r <= 1'b0;
      frm_row_r <= '0;
      frm_ph_r <= '0;
      scroll_r <= 1'b0;
      step_r <= '0;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cell_r <= cell_nxt;
      bsel_r <= bsel_nxt;
      frm_row_r <= frm_row_nxt;
      frm_ph_r <= frm_ph_nxt;
      step_r <= step_nxt;
      clr_r <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) scroll_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    tmp_r <= tmp_nxt;
    neg_r <= neg_nxt;
    spark_r <= spark_nxt;
    pix_r <= pix_nxt;
    red_r <= red_nxt;
    grn_r <= grn_nxt;
    blu_r <= blu_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.red = red_r;
  assign out_ch.green = grn_r;
  assign out_ch.blue = blu_r;
endmodule

FILE: sv/lta_mem.sv
module lta_mem #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [lta_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic signed [lta_pkg::WORD_W-1:0] rdata
);
  import lta_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/lta_alu.sv
module lta_alu #(
  parameter int FRAC_BITS = 16
) (
  input  lta_pkg::lta_op_t        op,
  input  logic signed [63:0]      a,
  input  logic signed [63:0]      b,
  output logic signed [63:0]      y
);
  import lta_pkg::*;

  logic signed [63:0] prod;

  // Shared unit: add, subtract, pass, or a fixed-point product truncated toward zero.
  always_comb begin
    prod = $signed(a[WORD_W-1:0]) * $signed(b[WORD_W-1:0]);
    case (op)
      OP_ADD:  y = a + b;
      OP_SUB:  y = a - b;
      OP_MUL:  y = (prod < 0) ? -((-prod) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
      OP_PASS: y = a;
      default: y = a;
    endcase
  end
endmodule

FILE: sv/lta_checker.sv
module lta_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_red
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready during work");
  a_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red >= 8'd155) else $error("red below floor");
endmodule

bind lava_texture_automaton_unit lta_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_red(out_ch.red));
